// ----- rtl/core/scw_pkg.sv -----
`default_nettype none
package scw_pkg;

  // default capacity of the sample store
  localparam int unsigned MAX_SAMPLES_DEF = 1024;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_FRACTION = 2'd0;
  localparam logic [1:0] REG_MODE_FRACTION   = 2'd1;
  localparam logic [1:0] REG_MODE_TOLERANCE  = 2'd2;

  // configuration reset values
  localparam logic [16:0] WINDOW_FRACTION_RST = 17'd44761;
  localparam logic [16:0] MODE_FRACTION_RST   = 17'd32768;
  localparam logic [30:0] MODE_TOLERANCE_RST  = 31'd0;

  // datapath operations
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_ACCEPT  = 4'd1;
  localparam logic [3:0] OP_INS     = 4'd2;
  localparam logic [3:0] OP_WMUL    = 4'd3;
  localparam logic [3:0] OP_WSET    = 4'd4;
  localparam logic [3:0] OP_SCAN    = 4'd5;
  localparam logic [3:0] OP_MEANSET = 4'd6;
  localparam logic [3:0] OP_DIVGO   = 4'd7;
  localparam logic [3:0] OP_MINIT   = 4'd8;
  localparam logic [3:0] OP_MREAD   = 4'd9;
  localparam logic [3:0] OP_MCHK    = 4'd10;
  localparam logic [3:0] OP_MMUL    = 4'd11;
  localparam logic [3:0] OP_MSET    = 4'd12;
  localparam logic [3:0] OP_MNEXT   = 4'd13;
  localparam logic [3:0] OP_FINISH  = 4'd14;

  // scan kinds
  localparam logic [1:0] KIND_WIN  = 2'd0;
  localparam logic [1:0] KIND_MEAN = 2'd1;
  localparam logic [1:0] KIND_MODE = 2'd2;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic ins_done;
    logic n_lt2;
    logic n_zero;
    logic scan_last;
    logic mean_empty;
    logic div_done;
    logic mode_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/core/scw_div.sv -----
`default_nettype none
module scw_div #(
  parameter int unsigned NW = 43,
  parameter int unsigned DW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo,
  output logic               done
);
  localparam int unsigned KW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [KW-1:0] cnt;
  logic          busy;
  logic [DW:0]   sh;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign sh   = {rem, quo[NW-1]};
  assign fits = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(NW);
        rem  <= '0;
        quo  <= num;
      end else if (busy) begin
        rem <= fits ? DW'(sh - {1'b0, den}) : DW'(sh);
        quo <= {quo[NW-2:0], fits};
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/core/scw_datapath.sv -----
`default_nettype none
module scw_datapath #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire scw_pkg::cmd_t        cmd,
  output scw_pkg::status_t          status,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [30:0]          cfg_data,
  input  wire logic signed [31:0]   sample_value,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [9:0]                window_first,
  output logic [9:0]                window_last,
  output logic [31:0]               window_width,
  output logic signed [31:0]        window_mean,
  output logic signed [31:0]        mode_estimate,
  output logic [10:0]               sample_total,
  output logic                      overflow
);
  import scw_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IW = $clog2(MAX_SAMPLES);
  localparam int unsigned SW = 32 + CW;
  localparam int unsigned PW = 17 + CW;

  // configuration
  logic [16:0] wfrac;
  logic [16:0] mfrac;
  logic [30:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      wfrac <= WINDOW_FRACTION_RST;
      mfrac <= MODE_FRACTION_RST;
      tol   <= MODE_TOLERANCE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_FRACTION: wfrac <= cfg_data[16:0];
        REG_MODE_FRACTION:   mfrac <= cfg_data[16:0];
        REG_MODE_TOLERANCE:  tol   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample store and working registers
  logic signed [31:0] mem [MAX_SAMPLES];
  logic signed [31:0] q_a, q_b;
  logic [IW-1:0]      ra, rb;
  logic               we;
  logic signed [31:0] wd;

  logic [CW-1:0]      count;
  logic               ovf;
  logic [CW-1:0]      pos;
  logic signed [31:0] v_reg;
  logic [PW-1:0]      prod;
  logic [IW-1:0]      s, i, i_end, lo, hi, im, imax;
  logic [IW-1:0]      wfirst, wlast;
  logic [1:0]         kind;
  logic               first_pend;
  logic               p_valid, p_first;
  logic [IW-1:0]      p_i;
  logic signed [32:0] dmin;
  logic signed [SW-1:0] sum;
  logic [31:0]        width_reg;
  logic signed [31:0] mean_reg, mode_reg;

  // combinational helpers
  logic               ins_done;
  logic [CW-1:0]      nm1;
  logic [CW:0]        t;
  logic [IW-1:0]      s_w, s_m, len, lm1;
  logic [CW:0]        sm_a;
  logic signed [32:0] d, span, msum;
  logic signed [34:0] dd, dm, tl;
  logic               lt1, lt2;
  logic               mode_done;
  logic [SW-1:0]      num;
  logic [SW-1:0]      quo;
  logic               div_done;
  logic signed [SW-1:0] q_signed;

  assign ins_done = (pos == '0) || (q_a <= v_reg);
  assign nm1      = count - CW'(1);
  assign t        = prod[PW-1:16];
  assign s_w      = (t > (CW+1)'(nm1)) ? IW'(nm1) : IW'(t);
  assign len      = hi - lo;
  assign lm1      = len - IW'(1);
  assign sm_a     = (t < (CW+1)'(2)) ? (CW+1)'(1) : t - (CW+1)'(1);
  assign s_m      = (sm_a > (CW+1)'(lm1)) ? lm1 : IW'(sm_a);

  assign d    = {q_a[31], q_a} - {q_b[31], q_b};
  assign span = {q_b[31], q_b} - {q_a[31], q_a};
  assign msum = {q_a[31], q_a} + {q_b[31], q_b};
  assign dd   = 35'(d);
  assign dm   = 35'(dmin);
  assign tl   = signed'({4'b0, tol});
  assign lt1  = dd < dm - tl;
  assign lt2  = dd - tl < dm;
  assign mode_done = (len == '0) || (len == IW'(1)) || (35'(span) < tl);

  // memory ports
  assign we = cmd.op == OP_INS;
  assign wd = ins_done ? v_reg : q_a;

  always_comb begin
    unique case (cmd.op)
      OP_INS:   ra = IW'(pos - CW'(2));
      OP_SCAN:  ra = i;
      OP_MREAD: ra = lo;
      default:  ra = IW'(count - CW'(1));
    endcase
    rb = (cmd.op == OP_SCAN) ? i - s : hi;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[IW'(pos)] <= wd;
    end
    q_a <= mem[ra];
    q_b <= mem[rb];
  end

  // divider for the window mean
  assign num      = sum[SW-1] ? SW'(-sum) : SW'(sum);
  assign q_signed = sum[SW-1] ? -signed'(quo) : signed'(quo);

  scw_div #(.NW(SW), .DW(IW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIVGO),
    .num   (num),
    .den   (wlast - wfirst),
    .quo   (quo),
    .done  (div_done)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ovf       <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= cmd.op == OP_SCAN;
      // result register loads on finish, empties on transfer
      if (cmd.op == OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_ACCEPT: begin
          if (count == CW'(MAX_SAMPLES)) begin
            ovf <= 1'b1;
          end
        end
        OP_INS: begin
          if (ins_done) begin
            count <= count + CW'(1);
          end
        end
        OP_FINISH: begin
          count <= '0;
          ovf   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_i     <= i;
    p_first <= first_pend;
    if (div_done) begin
      mean_reg <= q_signed[31:0];
    end
    unique case (cmd.op)
      OP_ACCEPT: begin
        v_reg <= sample_value;
        pos   <= count;
      end
      OP_INS: begin
        if (!ins_done) begin
          pos <= pos - CW'(1);
        end
      end
      OP_WMUL: prod <= PW'(wfrac) * PW'(count);
      OP_WSET: begin
        kind       <= KIND_WIN;
        s          <= s_w;
        i          <= s_w;
        i_end      <= IW'(nm1);
        first_pend <= 1'b1;
        wfirst     <= '0;
        wlast      <= '0;
        width_reg  <= '0;
        mean_reg   <= '0;
      end
      OP_SCAN: begin
        i          <= i + IW'(1);
        first_pend <= 1'b0;
      end
      OP_MEANSET: begin
        kind      <= KIND_MEAN;
        width_reg <= dmin[31:0];
        i         <= wfirst;
        i_end     <= wlast - IW'(1);
        sum       <= '0;
      end
      OP_MINIT: begin
        lo       <= '0;
        hi       <= IW'(nm1);
        mode_reg <= '0;
      end
      OP_MCHK: begin
        mode_reg <= (len == '0) ? q_a : msum[32:1];
      end
      OP_MMUL: prod <= PW'(mfrac) * PW'(len);
      OP_MSET: begin
        kind       <= KIND_MODE;
        s          <= s_m;
        i          <= lo + s_m;
        i_end      <= hi - IW'(1);
        first_pend <= 1'b1;
      end
      OP_MNEXT: begin
        lo <= im;
        hi <= imax;
      end
      OP_FINISH: begin
        window_first  <= 10'(wfirst);
        window_last   <= 10'(wlast);
        window_width  <= width_reg;
        window_mean   <= mean_reg;
        mode_estimate <= mode_reg;
        sample_total  <= 11'(count);
        overflow      <= ovf;
      end
      default: ;
    endcase

    // scan compare on data read in the cycle before
    if (p_valid) begin
      unique case (kind)
        KIND_WIN: begin
          if (p_first || d < dmin) begin
            dmin   <= d;
            wfirst <= p_i - s;
            wlast  <= p_i;
          end
        end
        KIND_MEAN: sum <= sum + SW'(q_a);
        KIND_MODE: begin
          if (p_first) begin
            dmin <= d;
            im   <= lo;
            imax <= p_i;
          end else if (lt1) begin
            dmin <= d;
            im   <= p_i - s;
            imax <= p_i;
          end else if (lt2) begin
            imax <= p_i;
          end
        end
        default: ;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    status.full       = count == CW'(MAX_SAMPLES);
    status.ins_done   = ins_done;
    status.n_lt2      = count < CW'(2);
    status.n_zero     = count == '0;
    status.scan_last  = i == i_end;
    status.mean_empty = wlast == wfirst;
    status.div_done   = div_done;
    status.mode_done  = mode_done;
    status.out_busy   = out_valid && out_stall;
  end

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES)) else $error("sample count past capacity");
  a_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |=> out_valid && count == '0 && !ovf)
    else $error("set not closed after result");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIVGO |-> wlast > wfirst) else $error("mean divide by zero");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/scw_ctrl.sv -----
`default_nettype none
module scw_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             last_sample,
  output logic                  in_stall,
  output scw_pkg::cmd_t         cmd,
  input  wire scw_pkg::status_t status
);
  import scw_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS     = 4'd1;
  localparam logic [3:0] S_WMUL    = 4'd2;
  localparam logic [3:0] S_WSET    = 4'd3;
  localparam logic [3:0] S_WSCAN   = 4'd4;
  localparam logic [3:0] S_WDRAIN  = 4'd5;
  localparam logic [3:0] S_MEANSET = 4'd6;
  localparam logic [3:0] S_ASCAN   = 4'd7;
  localparam logic [3:0] S_ADRAIN  = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_MINIT   = 4'd10;
  localparam logic [3:0] S_MREAD   = 4'd11;
  localparam logic [3:0] S_MCHK    = 4'd12;
  localparam logic [3:0] S_MMUL    = 4'd13;
  localparam logic [3:0] S_MSET    = 4'd14;
  localparam logic [3:0] S_MSCAN   = 4'd15;

  // mode scan drain and finish share encodings via sub-flag
  logic [3:0] state, state_next;
  logic       last_q, last_q_next;
  logic       sub, sub_next;

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      last_q <= 1'b0;
      sub    <= 1'b0;
    end else begin
      state  <= state_next;
      last_q <= last_q_next;
      sub    <= sub_next;
    end
  end

  // next state and command
  always_comb begin
    state_next  = state;
    last_q_next = last_q;
    sub_next    = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = OP_ACCEPT;
          last_q_next = last_sample;
          if (!status.full) begin
            state_next = S_INS;
          end else if (last_sample) begin
            state_next = S_WMUL;
          end
        end
      end
      S_INS: begin
        cmd.op = OP_INS;
        if (status.ins_done) begin
          state_next = last_q ? S_WMUL : S_IDLE;
        end
      end
      S_WMUL: begin
        cmd.op     = OP_WMUL;
        state_next = S_WSET;
      end
      S_WSET: begin
        cmd.op     = OP_WSET;
        state_next = status.n_lt2 ? S_MINIT : S_WSCAN;
      end
      S_WSCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_last) begin
          state_next = S_WDRAIN;
        end
      end
      S_WDRAIN: state_next = S_MEANSET;
      S_MEANSET: begin
        cmd.op     = OP_MEANSET;
        state_next = status.mean_empty ? S_MINIT : S_ASCAN;
      end
      S_ASCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_last) begin
          state_next = S_ADRAIN;
        end
      end
      S_ADRAIN: begin
        // last add lands first, the divide starts on the full sum
        if (sub) begin
          cmd.op     = OP_DIVGO;
          state_next = S_DIV;
        end else begin
          sub_next = 1'b1;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_MINIT;
        end
      end
      S_MINIT: begin
        // sub set: waiting to hand the result over
        if (sub) begin
          sub_next = 1'b1;
          if (!status.out_busy) begin
            cmd.op     = OP_FINISH;
            sub_next   = 1'b0;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op   = OP_MINIT;
          sub_next = 1'b1;
          if (!status.n_zero) begin
            sub_next   = 1'b0;
            state_next = S_MREAD;
          end
        end
      end
      S_MREAD: begin
        if (sub) begin
          // mode scan drained, now narrow the interval
          cmd.op = OP_MNEXT;
        end else begin
          cmd.op     = OP_MREAD;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        cmd.op = OP_MCHK;
        if (status.mode_done) begin
          sub_next   = 1'b1;
          state_next = S_MINIT;
        end else begin
          state_next = S_MMUL;
        end
      end
      S_MMUL: begin
        cmd.op     = OP_MMUL;
        state_next = S_MSET;
      end
      S_MSET: begin
        cmd.op     = OP_MSET;
        state_next = S_MSCAN;
      end
      S_MSCAN: begin
        if (sub) begin
          // last compare lands this cycle
          sub_next   = 1'b0;
          state_next = S_MREAD;
          sub_next   = 1'b1;
        end else begin
          cmd.op = OP_SCAN;
          if (status.scan_last) begin
            sub_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ins_from_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && in_valid && !status.full |=> state == S_INS)
    else $error("accepted sample not inserted");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_FINISH |-> !status.out_busy) else $error("result overwritten");
  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_WSCAN || state == S_ASCAN) && status.scan_last |=>
    state == S_WDRAIN || state == S_ADRAIN) else $error("scan ran past end");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/shortest_covering_window.sv -----
// Shortest covering window over a set of Q16.16 samples.
// Input channel: sample_value and last_sample, transfer when in_valid is high
// and in_stall is low. Each sample is placed in sorted order in the sample
// store; the stored samples larger than the new one move up one entry each
// (one store entry moved per cycle).
// Samples past capacity are dropped and flagged in overflow.
// A transfer with last_sample set closes the set. The block then scans the
// sorted store for the narrowest window, sums the window, divides for the
// mean in a bit-serial divider and narrows the mode interval step by step,
// then presents one result.
// Output channel: the result fields transfer when out_valid is high and
// out_stall is low. The result sits in an output register, so new samples
// are taken while it waits; a following result waits for it to be taken.
// cfg_write with cfg_index writes window_fraction, mode_fraction or
// mode_tolerance; write only while the block is idle.
// Reset (rst, synchronous) empties the set, clears overflow and restores
// the register defaults; it needs no clearing pass.
`default_nettype none
module shortest_covering_window #(
  parameter int unsigned MAX_SAMPLES = scw_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] sample_value,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [9:0]              window_first,
  output logic [9:0]              window_last,
  output logic [31:0]             window_width,
  output logic signed [31:0]      window_mean,
  output logic signed [31:0]      mode_estimate,
  output logic [10:0]             sample_total,
  output logic                    overflow,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data
);
  import scw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  scw_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .status      (status)
  );

  // store, scans and result registers
  scw_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_value  (sample_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .window_first  (window_first),
    .window_last   (window_last),
    .window_width  (window_width),
    .window_mean   (window_mean),
    .mode_estimate (mode_estimate),
    .sample_total  (sample_total),
    .overflow      (overflow)
  );
endmodule
`default_nettype wire
